### rtl/core/offset_table_blend_unit_defines.svh
// Assertion macros shared by the offset table blend unit.
`ifndef OFFSET_TABLE_BLEND_UNIT_DEFINES_SVH
`define OFFSET_TABLE_BLEND_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define OBTU_ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("offset table blend unit: check failed");
`define OBTU_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("offset table blend unit: check failed after reset");
`else
`define OBTU_ASSERT_RST(label, clk, rst, prop)
`define OBTU_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

### rtl/core/obtu_pkg.sv
// Shared widths, codes and arithmetic constants of the offset table blend unit.
package obtu_pkg;

   localparam int OFFSET_WIDTH        = 16;
   localparam int INDEX_WIDTH         = 8;
   localparam int ENTRY_INDEX_WIDTH   = 4;
   localparam int WEIGHT_WIDTH        = 8;

   localparam int TABLE_DEPTH_DEFAULT = 14;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_EVAL  = 1'b1;

   localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_FULL = 8'd100;

   // |a*w + b*(100-w)| <= 3276800, so 25 bits signed and a 22-bit magnitude
   localparam int SUM_WIDTH   = 25;
   localparam int MAG_WIDTH   = 22;
   localparam int RECIP_SHIFT = 29;
   localparam int RECIP_WIDTH = 23;
   localparam int PROD_WIDTH  = MAG_WIDTH + RECIP_WIDTH;

   // ceil(2^29 / 100): exact quotient for every magnitude below 2^22
   localparam logic [RECIP_WIDTH-1:0] RECIP_MULT =
      RECIP_WIDTH'(((64'd1 << RECIP_SHIFT) + 64'(WEIGHT_FULL) - 64'd1) / 64'(WEIGHT_FULL));
   localparam logic [MAG_WIDTH-1:0] ROUND_HALF = MAG_WIDTH'(50);

   localparam logic signed [OFFSET_WIDTH-1:0] OFFSET_MIN = 16'sh8000;

   localparam int BLEND_LATENCY = 3;

   typedef struct packed {
      logic [WEIGHT_WIDTH-1:0] tar;
      logic [WEIGHT_WIDTH-1:0] cur;
      logic [WEIGHT_WIDTH-1:0] trans;
   } weights_type;

   localparam int WEIGHTS_WIDTH = $bits(weights_type);

endpackage

### rtl/core/obtu_front.sv
// Front end: takes request items, clamps indices and qualifies table writes.
module obtu_front #(
   parameter int TABLE_DEPTH = obtu_pkg::TABLE_DEPTH_DEFAULT,
   parameter int ITEM_WIDTH  = 2 + obtu_pkg::OFFSET_WIDTH
                               + 5 * $clog2(TABLE_DEPTH) + obtu_pkg::WEIGHTS_WIDTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_func,
   input  logic [obtu_pkg::ENTRY_INDEX_WIDTH-1:0] req_entry_index,
   input  logic signed [obtu_pkg::OFFSET_WIDTH-1:0] req_entry_value,
   input  logic [obtu_pkg::INDEX_WIDTH-1:0]       req_cur_first_index,
   input  logic [obtu_pkg::INDEX_WIDTH-1:0]       req_cur_second_index,
   input  logic [obtu_pkg::INDEX_WIDTH-1:0]       req_tar_first_index,
   input  logic [obtu_pkg::INDEX_WIDTH-1:0]       req_tar_second_index,
   input  logic [obtu_pkg::WEIGHT_WIDTH-1:0]      req_tar_weight,
   input  logic [obtu_pkg::WEIGHT_WIDTH-1:0]      req_cur_weight,
   input  logic [obtu_pkg::WEIGHT_WIDTH-1:0]      req_transition_weight,
   output logic                                   push,
   output logic [ITEM_WIDTH-1:0]                  push_item,
   input  logic                                   queue_full
);
   import obtu_pkg::*;

   localparam int ADDR_WIDTH = $clog2(TABLE_DEPTH);

   function automatic logic [ADDR_WIDTH-1:0] clamp_index(input logic [INDEX_WIDTH-1:0] idx);
      logic [INDEX_WIDTH-1:0] depth_idx;
      depth_idx = INDEX_WIDTH'(TABLE_DEPTH);
      if (idx == '0) begin
         return '0;
      end else if (idx > depth_idx) begin
         return ADDR_WIDTH'(TABLE_DEPTH - 1);
      end else begin
         return ADDR_WIDTH'(idx - INDEX_WIDTH'(1));
      end
   endfunction

   logic                  valid_ff, valid_in;
   logic [ITEM_WIDTH-1:0] item_ff;
   logic                  accept;
   logic                  is_eval;
   logic                  wr_en;
   weights_type           weights;

   assign req_stall = valid_ff && queue_full;
   assign accept    = req_valid && !req_stall;
   assign push      = valid_ff && !queue_full;
   assign push_item = item_ff;

   assign is_eval = (req_func == FUNC_EVAL);
   assign wr_en   = (INDEX_WIDTH'(req_entry_index) < INDEX_WIDTH'(TABLE_DEPTH));
   assign weights = '{tar: req_tar_weight, cur: req_cur_weight, trans: req_transition_weight};

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= {is_eval, wr_en, ADDR_WIDTH'(req_entry_index), req_entry_value,
                     clamp_index(req_tar_first_index), clamp_index(req_tar_second_index),
                     clamp_index(req_cur_first_index), clamp_index(req_cur_second_index),
                     weights};
      end
   end

endmodule

### rtl/core/obtu_queue.sv
// Small item queue between the front end and the table/blend back end.
module obtu_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = obtu_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_item,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_item,
   output logic             full,
   output logic             empty
);
   import obtu_pkg::*;

   localparam int PTR_WIDTH   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]       slot_ff [DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   assign full     = (count_ff == COUNT_WIDTH'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_WIDTH'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_WIDTH'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + COUNT_WIDTH'(1);
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### rtl/core/obtu_blend.sv
// Three-stage percentage blend of two offsets with round half away from zero.
module obtu_blend (
   input  logic                                     clock,
   input  logic                                     advance,
   input  logic signed [obtu_pkg::OFFSET_WIDTH-1:0] first_value,
   input  logic signed [obtu_pkg::OFFSET_WIDTH-1:0] second_value,
   input  logic [obtu_pkg::WEIGHT_WIDTH-1:0]        weight,
   output logic signed [obtu_pkg::OFFSET_WIDTH-1:0] result
);
   import obtu_pkg::*;

   logic [WEIGHT_WIDTH-2:0]        w_low, w_comp;
   logic signed [SUM_WIDTH-1:0]    first_ext, second_ext, w_ext, comp_ext, sum_in;
   logic                           take_first_in, take_second_in;

   logic signed [SUM_WIDTH-1:0]    sum_ff;
   logic                           take_first_s1_ff, take_second_s1_ff;
   logic signed [OFFSET_WIDTH-1:0] first_s1_ff, second_s1_ff;

   logic                           positive;
   logic signed [SUM_WIDTH-1:0]    mag_full;
   logic [MAG_WIDTH-1:0]           mag_round;
   logic [PROD_WIDTH-1:0]          product_in;

   logic [PROD_WIDTH-1:0]          product_ff;
   logic                           negate_ff;
   logic                           take_first_s2_ff, take_second_s2_ff;
   logic signed [OFFSET_WIDTH-1:0] first_s2_ff, second_s2_ff;

   logic [OFFSET_WIDTH-1:0]        quotient;
   logic signed [OFFSET_WIDTH-1:0] rounded, result_in;
   logic signed [OFFSET_WIDTH-1:0] result_ff;

   // weighted sum
   assign w_low          = weight[WEIGHT_WIDTH-2:0];
   assign w_comp         = (WEIGHT_WIDTH - 1)'(WEIGHT_FULL) - w_low;
   assign first_ext      = SUM_WIDTH'(first_value);
   assign second_ext     = SUM_WIDTH'(second_value);
   assign w_ext          = $signed(SUM_WIDTH'(w_low));
   assign comp_ext       = $signed(SUM_WIDTH'(w_comp));
   assign sum_in         = first_ext * w_ext + second_ext * comp_ext;
   assign take_second_in = (weight == '0);
   assign take_first_in  = (weight >= WEIGHT_FULL);

   // rounded magnitude times reciprocal of 100
   assign positive   = (sum_ff > 0);
   assign mag_full   = positive ? sum_ff : -sum_ff;
   assign mag_round  = MAG_WIDTH'(mag_full) + ROUND_HALF;
   assign product_in = PROD_WIDTH'(mag_round) * PROD_WIDTH'(RECIP_MULT);

   // quotient, sign and outright selection
   assign quotient = product_ff[RECIP_SHIFT +: OFFSET_WIDTH];
   assign rounded  = negate_ff ? -$signed(quotient) : $signed(quotient);

   always_comb begin
      if (take_second_s2_ff) begin
         result_in = second_s2_ff;
      end else if (take_first_s2_ff) begin
         result_in = first_s2_ff;
      end else begin
         result_in = rounded;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sum_ff            <= sum_in;
         take_first_s1_ff  <= take_first_in;
         take_second_s1_ff <= take_second_in;
         first_s1_ff       <= first_value;
         second_s1_ff      <= second_value;

         product_ff        <= product_in;
         negate_ff         <= !positive;
         take_first_s2_ff  <= take_first_s1_ff;
         take_second_s2_ff <= take_second_s1_ff;
         first_s2_ff       <= first_s1_ff;
         second_s2_ff      <= second_s1_ff;

         result_ff         <= result_in;
      end
   end

   assign result = result_ff;

endmodule

### rtl/core/obtu_back.sv
// Back end: offset table, two-level blend pipeline and response register.
module obtu_back #(
   parameter int TABLE_DEPTH = obtu_pkg::TABLE_DEPTH_DEFAULT,
   parameter int ITEM_WIDTH  = 2 + obtu_pkg::OFFSET_WIDTH
                               + 5 * $clog2(TABLE_DEPTH) + obtu_pkg::WEIGHTS_WIDTH
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic [ITEM_WIDTH-1:0]                    queue_item,
   input  logic                                     queue_empty,
   output logic                                     queue_pop,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [obtu_pkg::OFFSET_WIDTH-1:0] rsp_final_offset,
   output logic signed [obtu_pkg::OFFSET_WIDTH-1:0] rsp_target_offset,
   output logic signed [obtu_pkg::OFFSET_WIDTH-1:0] rsp_current_offset
);
   import obtu_pkg::*;

   localparam int ADDR_WIDTH = $clog2(TABLE_DEPTH);
   localparam int CB_POS     = WEIGHTS_WIDTH;
   localparam int CA_POS     = CB_POS + ADDR_WIDTH;
   localparam int TB_POS     = CA_POS + ADDR_WIDTH;
   localparam int TA_POS     = TB_POS + ADDR_WIDTH;
   localparam int WD_POS     = TA_POS + ADDR_WIDTH;
   localparam int WA_POS     = WD_POS + OFFSET_WIDTH;
   localparam int WEN_POS    = WA_POS + ADDR_WIDTH;
   localparam int EVAL_POS   = WEN_POS + 1;
   localparam int LATENCY    = 1 + 2 * BLEND_LATENCY;

   logic                           is_eval, wr_en;
   logic [ADDR_WIDTH-1:0]          wr_addr, tar_a_addr, tar_b_addr, cur_a_addr, cur_b_addr;
   logic signed [OFFSET_WIDTH-1:0] wr_data;
   weights_type                    weights;
   logic                           advance, do_write, do_read;

   logic signed [OFFSET_WIDTH-1:0] tar_mem [TABLE_DEPTH];
   logic signed [OFFSET_WIDTH-1:0] cur_mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]         entry_valid_ff;

   logic signed [OFFSET_WIDTH-1:0] tar_first_ff, tar_second_ff, cur_first_ff, cur_second_ff;
   logic                           tar_first_ok_ff, tar_second_ok_ff;
   logic                           cur_first_ok_ff, cur_second_ok_ff;
   weights_type                    weights_ff;
   logic signed [OFFSET_WIDTH-1:0] tar_first, tar_second, cur_first, cur_second;

   logic signed [OFFSET_WIDTH-1:0] tar_result, cur_result, fin_result, final_in;
   logic [WEIGHT_WIDTH-1:0]        trans_pipe_ff [BLEND_LATENCY];
   logic signed [OFFSET_WIDTH-1:0] tar_pipe_ff [BLEND_LATENCY];
   logic signed [OFFSET_WIDTH-1:0] cur_pipe_ff [BLEND_LATENCY];
   logic [LATENCY-1:0]             stage_valid_ff;

   logic                           rsp_valid_ff;
   logic signed [OFFSET_WIDTH-1:0] final_ff, target_ff, current_ff;

   assign is_eval    = queue_item[EVAL_POS];
   assign wr_en      = queue_item[WEN_POS];
   assign wr_addr    = queue_item[WA_POS +: ADDR_WIDTH];
   assign wr_data    = $signed(queue_item[WD_POS +: OFFSET_WIDTH]);
   assign tar_a_addr = queue_item[TA_POS +: ADDR_WIDTH];
   assign tar_b_addr = queue_item[TB_POS +: ADDR_WIDTH];
   assign cur_a_addr = queue_item[CA_POS +: ADDR_WIDTH];
   assign cur_b_addr = queue_item[CB_POS +: ADDR_WIDTH];
   assign weights    = queue_item[WEIGHTS_WIDTH-1:0];

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign queue_pop = advance && !queue_empty;
   assign do_write  = queue_pop && !is_eval && wr_en;
   assign do_read   = queue_pop && is_eval;

   // two copies of the table give four read ports
   always_ff @(posedge clock) begin
      if (do_write) begin
         tar_mem[wr_addr] <= wr_data;
         cur_mem[wr_addr] <= wr_data;
      end
      if (do_read) begin
         tar_first_ff     <= tar_mem[tar_a_addr];
         tar_second_ff    <= tar_mem[tar_b_addr];
         cur_first_ff     <= cur_mem[cur_a_addr];
         cur_second_ff    <= cur_mem[cur_b_addr];
         tar_first_ok_ff  <= entry_valid_ff[tar_a_addr];
         tar_second_ok_ff <= entry_valid_ff[tar_b_addr];
         cur_first_ok_ff  <= entry_valid_ff[cur_a_addr];
         cur_second_ok_ff <= entry_valid_ff[cur_b_addr];
         weights_ff       <= weights;
      end
   end

   // unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
      end else if (do_write) begin
         entry_valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign tar_first  = tar_first_ok_ff  ? tar_first_ff  : '0;
   assign tar_second = tar_second_ok_ff ? tar_second_ff : '0;
   assign cur_first  = cur_first_ok_ff  ? cur_first_ff  : '0;
   assign cur_second = cur_second_ok_ff ? cur_second_ff : '0;

   obtu_blend u_tar_blend (
      .clock        (clock),
      .advance      (advance),
      .first_value  (tar_first),
      .second_value (tar_second),
      .weight       (weights_ff.tar),
      .result       (tar_result)
   );

   obtu_blend u_cur_blend (
      .clock        (clock),
      .advance      (advance),
      .first_value  (cur_first),
      .second_value (cur_second),
      .weight       (weights_ff.cur),
      .result       (cur_result)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         trans_pipe_ff[0] <= weights_ff.trans;
         tar_pipe_ff[0]   <= tar_result;
         cur_pipe_ff[0]   <= cur_result;
         for (int i = 1; i < BLEND_LATENCY; i++) begin
            trans_pipe_ff[i] <= trans_pipe_ff[i-1];
            tar_pipe_ff[i]   <= tar_pipe_ff[i-1];
            cur_pipe_ff[i]   <= cur_pipe_ff[i-1];
         end
      end
   end

   // transition weight travels beside the pair blends
   obtu_blend u_fin_blend (
      .clock        (clock),
      .advance      (advance),
      .first_value  (tar_result),
      .second_value (cur_result),
      .weight       (trans_pipe_ff[BLEND_LATENCY-1]),
      .result       (fin_result)
   );

   assign final_in = (fin_result == OFFSET_MIN) ? OFFSET_MIN : fin_result - 16'sd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else if (advance) begin
         stage_valid_ff <= {stage_valid_ff[LATENCY-2:0], do_read};
         rsp_valid_ff   <= stage_valid_ff[LATENCY-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         final_ff   <= final_in;
         target_ff  <= tar_pipe_ff[BLEND_LATENCY-1];
         current_ff <= cur_pipe_ff[BLEND_LATENCY-1];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_final_offset   = final_ff;
   assign rsp_target_offset  = target_ff;
   assign rsp_current_offset = current_ff;

endmodule

### rtl/core/offset_table_blend_unit.sv
// Top level of the offset table blend unit: front end, item queue and back end.
//
// Holds a table of TABLE_DEPTH signed 16-bit offsets, zero after reset (per-entry valid
// flags, so there is no clearing pass), loaded by write items (func 0; indices at or
// beyond the depth are dropped). An evaluate item (func 1) clamps its four one-based
// indices, blends the target and current pairs and then blends those two by the
// transition weight; the response carries that result minus one (saturated) and both
// intermediate values. One item per clock is sustained in both directions unless the
// response stalls; an evaluate item passes the front register, queue, table read, three
// stages for the pair blends and three for the transition blend, response register.
// Four reads per cycle come from two identical copies of the table. A stalled response
// holds the whole back end; the front register and queue keep taking items until full.
`include "offset_table_blend_unit_defines.svh"
module offset_table_blend_unit #(
   parameter int TABLE_DEPTH = obtu_pkg::TABLE_DEPTH_DEFAULT,
   parameter int QUEUE_DEPTH = obtu_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic                                     req_func,
   input  logic [obtu_pkg::ENTRY_INDEX_WIDTH-1:0]   req_entry_index,
   input  logic signed [obtu_pkg::OFFSET_WIDTH-1:0] req_entry_value,
   input  logic [obtu_pkg::INDEX_WIDTH-1:0]         req_cur_first_index,
   input  logic [obtu_pkg::INDEX_WIDTH-1:0]         req_cur_second_index,
   input  logic [obtu_pkg::INDEX_WIDTH-1:0]         req_tar_first_index,
   input  logic [obtu_pkg::INDEX_WIDTH-1:0]         req_tar_second_index,
   input  logic [obtu_pkg::WEIGHT_WIDTH-1:0]        req_tar_weight,
   input  logic [obtu_pkg::WEIGHT_WIDTH-1:0]        req_cur_weight,
   input  logic [obtu_pkg::WEIGHT_WIDTH-1:0]        req_transition_weight,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [obtu_pkg::OFFSET_WIDTH-1:0] rsp_final_offset,
   output logic signed [obtu_pkg::OFFSET_WIDTH-1:0] rsp_target_offset,
   output logic signed [obtu_pkg::OFFSET_WIDTH-1:0] rsp_current_offset
);
   import obtu_pkg::*;

   localparam int ITEM_WIDTH = 2 + OFFSET_WIDTH + 5 * $clog2(TABLE_DEPTH) + WEIGHTS_WIDTH;

   logic                  push, queue_pop, queue_full, queue_empty;
   logic [ITEM_WIDTH-1:0] push_item, pop_item;

   obtu_front #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ITEM_WIDTH  (ITEM_WIDTH)
   ) u_front (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_func              (req_func),
      .req_entry_index       (req_entry_index),
      .req_entry_value       (req_entry_value),
      .req_cur_first_index   (req_cur_first_index),
      .req_cur_second_index  (req_cur_second_index),
      .req_tar_first_index   (req_tar_first_index),
      .req_tar_second_index  (req_tar_second_index),
      .req_tar_weight        (req_tar_weight),
      .req_cur_weight        (req_cur_weight),
      .req_transition_weight (req_transition_weight),
      .push                  (push),
      .push_item             (push_item),
      .queue_full            (queue_full)
   );

   obtu_queue #(
      .WIDTH (ITEM_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (queue_pop),
      .pop_item  (pop_item),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   obtu_back #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ITEM_WIDTH  (ITEM_WIDTH)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .queue_item         (pop_item),
      .queue_empty        (queue_empty),
      .queue_pop          (queue_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_final_offset   (rsp_final_offset),
      .rsp_target_offset  (rsp_target_offset),
      .rsp_current_offset (rsp_current_offset)
   );

   `OBTU_ASSERT_RST(a_queue_full_empty, clock, reset, !(queue_full && queue_empty))
   `OBTU_ASSERT_RST(a_stall_needs_full, clock, reset, req_stall |-> queue_full)
   `OBTU_ASSERT_RST(a_pop_not_empty, clock, reset, queue_pop |-> !queue_empty)
   `OBTU_ASSERT_RST(a_final_below_max, clock, reset, rsp_valid |-> rsp_final_offset != 16'sh7fff)
   `OBTU_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid && !req_stall)

endmodule
